/* sv/hd2_pkg.sv */
`default_nettype none

package hd2_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;
  // haar sums of four 8-bit pixels: -510..1020
  localparam int unsigned SUM_W   = 12;
  // inverse of four kept sums: -1530..2550
  localparam int unsigned REC_W   = 14;

  localparam logic [CFG_W-1:0] PAIRS_RST  = 10'd256;
  localparam logic [CFG_W-1:0] THRESH_RST = 10'd41;

  typedef enum logic [0:0] {
    REG_PAIRS  = 1'b0,
    REG_THRESH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic [COL_W-1:0] out_column;
    logic             lower_row;
    logic             block_last;
  } res_t;

  // one 2x2 block: a b upper, c d lower, col is the odd column
  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] d;
    logic [COL_W-1:0] col;
  } blk_t;

endpackage

`default_nettype wire

/* sv/hd2_if.sv */
`default_nettype none

interface hd2_pix_if;
  logic          valid;
  logic          ready;
  hd2_pkg::pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hd2_res_if;
  logic          valid;
  logic          ready;
  hd2_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/hd2_front.sv */
`default_nettype none

module hd2_front #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [hd2_pkg::CFG_W-1:0]        pairs_i,
  hd2_pix_if.sink                               pix_i,
  input  wire logic [hd2_pkg::QCNT_W-1:0]       q_cnt_i,
  output logic                                  blk_valid_o,
  output hd2_pkg::blk_t                         blk_o
);

  localparam int CW    = $clog2(MAX_LINE_WIDTH);
  localparam int LIMIT = (MAX_LINE_WIDTH / 2) * 2;
  localparam int LW    = $clog2(LIMIT + 1);
  localparam int BD    = MAX_LINE_WIDTH / 2;
  localparam int AW    = (BD > 1) ? $clog2(BD) : 1;

  logic [CW-1:0] col_q;
  logic          lower_q;
  logic [hd2_pkg::PIX_W-1:0] left_q;
  logic          pend_q;

  // line store split into even and odd columns, one read port each
  logic [hd2_pkg::PIX_W-1:0] even_mem [BD];
  logic [hd2_pkg::PIX_W-1:0] odd_mem  [BD];

  logic [hd2_pkg::PIX_W-1:0] ra_q, rb_q, pc_q, pd_q;
  logic [hd2_pkg::COL_W-1:0] pcol_q;

  logic [hd2_pkg::CFG_W:0]   two_p;
  logic [LW-1:0]             w_eff;
  logic [CW-1:0]             cur_col;
  logic                      cur_lower;
  logic                      wrap;
  logic                      accept;
  logic [AW-1:0]             addr;
  logic                      wr_even, wr_odd, rd;
  logic [hd2_pkg::PIX_W-1:0] px;

  assign px        = pix_i.data.pixel;
  assign two_p     = {((pairs_i == '0) ? 10'd1 : pairs_i), 1'b0};
  assign w_eff     = (32'(two_p) > 32'(LIMIT)) ? LW'(LIMIT) : LW'(two_p);
  assign cur_col   = pix_i.data.frame_start ? '0 : col_q;
  assign cur_lower = pix_i.data.frame_start ? 1'b0 : lower_q;
  // also wraps when the width shrank below the current column
  assign wrap      = (LW'(cur_col) + LW'(1)) >= w_eff;

  // room for everything already in flight
  assign pix_i.ready = ({1'b0, q_cnt_i} + {{hd2_pkg::QCNT_W{1'b0}}, pend_q})
                       < (hd2_pkg::QCNT_W + 1)'(hd2_pkg::QDEPTH);
  assign accept  = pix_i.valid && pix_i.ready;
  assign addr    = AW'(cur_col >> 1);
  assign wr_even = accept && !cur_lower && !cur_col[0];
  assign wr_odd  = accept && !cur_lower && cur_col[0];
  assign rd      = accept && cur_lower && cur_col[0];

  always_ff @(posedge clk_i) begin
    if (wr_even) begin
      even_mem[addr] <= px;
    end
    if (wr_odd) begin
      odd_mem[addr] <= px;
    end
    if (rd) begin
      ra_q   <= even_mem[addr];
      rb_q   <= odd_mem[addr];
      pc_q   <= left_q;
      pd_q   <= px;
      pcol_q <= hd2_pkg::COL_W'(cur_col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      lower_q <= 1'b0;
      left_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      pend_q <= rd;
      if (accept) begin
        col_q   <= wrap ? '0 : CW'(cur_col + 1'b1);
        lower_q <= wrap ? !cur_lower : cur_lower;
        if (cur_lower && !cur_col[0]) begin
          left_q <= px;
        end
      end
    end
  end

  assign blk_valid_o = pend_q;
  assign blk_o = '{a: ra_q, b: rb_q, c: pc_q, d: pd_q, col: pcol_q};

endmodule

`default_nettype wire

/* sv/hd2_queue.sv */
`default_nettype none

module hd2_queue (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire hd2_pkg::blk_t              push_data_i,
  input  wire logic                       pop_i,
  output hd2_pkg::blk_t                   head_o,
  output logic                            head_valid_o,
  output logic [hd2_pkg::QCNT_W-1:0]      cnt_o
);

  hd2_pkg::blk_t                  entry_q [hd2_pkg::QDEPTH];
  logic [hd2_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [hd2_pkg::QCNT_W-1:0]     cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o       = entry_q[rd_ptr_q];
  assign head_valid_o = (cnt_q != '0);
  assign cnt_o        = cnt_q;

endmodule

`default_nettype wire

/* sv/hd2_back.sv */
`default_nettype none

module hd2_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [hd2_pkg::CFG_W-1:0]  thresh_i,
  input  wire hd2_pkg::blk_t              head_i,
  input  wire logic                       head_valid_i,
  output logic                            pop_o,
  hd2_res_if.source                       res_o
);

  localparam int SW = hd2_pkg::SUM_W;
  localparam int RW = hd2_pkg::REC_W;

  function automatic logic signed [SW-1:0] keep_f(input logic signed [SW-1:0] s,
                                                  input logic [hd2_pkg::CFG_W-1:0] t);
    logic [SW-1:0] m;
    m = (s < 0) ? SW'(-s) : SW'(s);
    return (m < SW'(t)) ? '0 : s;
  endfunction

  logic signed [SW-1:0] sa, sb, sc, sd;
  logic signed [SW-1:0] ll_q, lh_q, hl_q, hh_q;
  logic [hd2_pkg::COL_W-1:0] col_q;
  logic [1:0]           k_q;
  logic                 cf_valid_q;
  logic                 adv;

  logic signed [RW-1:0] ll_x, lh_x, hl_x, hh_x, v, r, q;
  logic [hd2_pkg::PIX_W-1:0] pix;
  logic                 o_valid_q;
  hd2_pkg::res_t        res_q;

  assign sa = $signed({4'b0, head_i.a});
  assign sb = $signed({4'b0, head_i.b});
  assign sc = $signed({4'b0, head_i.c});
  assign sd = $signed({4'b0, head_i.d});

  assign adv   = cf_valid_q && (!o_valid_q || res_o.ready);
  assign pop_o = head_valid_i && (!cf_valid_q || (adv && (k_q == 2'd3)));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ll_q  <= keep_f(sa + sb + sc + sd, thresh_i);
      lh_q  <= keep_f(sa + sb - sc - sd, thresh_i);
      hl_q  <= keep_f(sa - sb + sc - sd, thresh_i);
      hh_q  <= keep_f(sa - sb - sc + sd, thresh_i);
      col_q <= head_i.col;
    end
  end

  // inverse for pixel k: lh sign from row, hl from column, hh from both
  assign ll_x = RW'(ll_q);
  assign lh_x = RW'(lh_q);
  assign hl_x = RW'(hl_q);
  assign hh_x = RW'(hh_q);

  always_comb begin
    v = ll_x + (k_q[1] ? -lh_x : lh_x) + (k_q[0] ? -hl_x : hl_x)
        + ((k_q[0] ^ k_q[1]) ? -hh_x : hh_x);
    r = v + RW'(2);
    q = r >>> 2;
    // divide by four, half away from zero, clamp
    if (v <= 0) begin
      pix = '0;
    end else if (q > RW'(255)) begin
      pix = 8'd255;
    end else begin
      pix = q[hd2_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cf_valid_q <= 1'b0;
      k_q        <= '0;
      o_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        cf_valid_q <= 1'b1;
        k_q        <= '0;
      end else if (adv) begin
        k_q <= k_q + 1'b1;
        if (k_q == 2'd3) begin
          cf_valid_q <= 1'b0;
        end
      end
      if (adv) begin
        o_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.out_pixel  <= pix;
      res_q.out_column <= k_q[0] ? col_q : {col_q[hd2_pkg::COL_W-1:1], 1'b0};
      res_q.lower_row  <= k_q[1];
      res_q.block_last <= (k_q == 2'd3);
    end
  end

  assign res_o.valid = o_valid_q;
  assign res_o.data  = res_q;

endmodule

`default_nettype wire

/* sv/haar_2x2_threshold_denoise.sv */
// 2x2 haar denoiser with hard threshold on all four sums.
// pix_i takes grey pixels in raster order (frame_start marks the first pixel
// of a frame); res_o gives four reconstructed pixels per 2x2 block, in the
// order upper left, upper right, lower left, lower right, each with its
// column, row-in-block flag and a last flag on the fourth.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 pairs per line, 1 threshold); write only while the block is idle.
// Throughput: upper-row pixels are taken one per cycle while the block queue
// has room. A lower-row pixel pair yields four results and res_o moves one
// per cycle when not stalled, so lower rows are limited by the result port.
// The first pixel of a block reaches res_o after its lower-right pixel is
// taken and its block passes the front registers, the queue, the sums and
// threshold registers and the inverse into the result register; the other
// three follow on consecutive cycles when res_o is not stalled.
// A four-entry block queue sits between the line store side and the
// reconstruction side; a stall on res_o fills it and then drops pix_i.ready.
// Reset clears position, row and queue state; the line store is not cleared
// and is written by the upper row before the lower row reads it.
`default_nettype none

module haar_2x2_threshold_denoise #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [0:0]                   cfg_idx_i,
  input  wire logic [hd2_pkg::CFG_W-1:0]    cfg_wdata_i,
  hd2_pix_if.sink                           pix_i,
  hd2_res_if.source                         res_o
);

  logic [hd2_pkg::CFG_W-1:0]  pairs_q, thresh_q;
  logic                       blk_valid;
  hd2_pkg::blk_t              blk, head;
  logic                       head_valid, pop;
  logic [hd2_pkg::QCNT_W-1:0] q_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_q  <= hd2_pkg::PAIRS_RST;
      thresh_q <= hd2_pkg::THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (hd2_pkg::cfg_reg_e'(cfg_idx_i))
        hd2_pkg::REG_PAIRS:  pairs_q  <= cfg_wdata_i;
        hd2_pkg::REG_THRESH: thresh_q <= cfg_wdata_i;
      endcase
    end
  end

  hd2_front #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pairs_i    (pairs_q),
    .pix_i      (pix_i),
    .q_cnt_i    (q_cnt),
    .blk_valid_o(blk_valid),
    .blk_o      (blk)
  );

  hd2_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (blk_valid),
    .push_data_i (blk),
    .pop_i       (pop),
    .head_o      (head),
    .head_valid_o(head_valid),
    .cnt_o       (q_cnt)
  );

  hd2_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thresh_i    (thresh_q),
    .head_i      (head),
    .head_valid_i(head_valid),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

/* sv/hd2_checker.sv */
`default_nettype none

module hd2_checker (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    out_valid_i,
  input wire logic    out_ready_i,
  input wire hd2_pkg::res_t out_data_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // last pixel of a block is the lower right one
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.block_last |->
      out_data_i.lower_row && out_data_i.out_column[0])
    else $error("block_last on wrong block position");

  // upper right follows upper left without a gap
  a_pair_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_data_i.lower_row && !out_data_i.out_column[0]
    |=> out_valid_i && !out_data_i.lower_row && !out_data_i.block_last
        && (out_data_i.out_column == $past(out_data_i.out_column) + 10'd1))
    else $error("block pixel order broken");

endmodule

bind haar_2x2_threshold_denoise hd2_checker u_hd2_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .out_data_i (res_o.data)
);

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int unsigned LINE_MAX = 1024;
  localparam int unsigned PIX_B = hd2_pkg::PIX_W;
  localparam int unsigned CFG_B = hd2_pkg::CFG_W;
  localparam int unsigned COL_B = hd2_pkg::COL_W;
  // slack after the last result before a register write or the end of the run
  localparam int unsigned SETTLE_CYC = 8;

  // predicts the four rebuilt pixels of every 2x2 block and checks them in order
  class haar_denoise_sb;
    logic [PIX_B-1:0]   line_mem [LINE_MAX];
    bit                 line_seen [LINE_MAX];
    int unsigned        col_pos;
    bit                 in_lower;
    logic [PIX_B-1:0]   left_px;
    logic [CFG_B-1:0]   pairs_reg;
    logic [CFG_B-1:0]   thresh_reg;
    hd2_pkg::res_t      pixels_due [$];
    int unsigned        n_bad;

    function new();
      col_pos = 0;
      in_lower = 0;
      left_px = '0;
      pairs_reg = hd2_pkg::PAIRS_RST;
      thresh_reg = hd2_pkg::THRESH_RST;
      n_bad = 0;
      foreach (line_seen[i]) line_seen[i] = 0;
    endfunction

    function void set_reg(hd2_pkg::cfg_reg_e idx, logic [CFG_B-1:0] val);
      case (idx)
        hd2_pkg::REG_PAIRS:  pairs_reg = val;
        hd2_pkg::REG_THRESH: thresh_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned line_len();
      int unsigned w;
      w = 2 * ((pairs_reg == 0) ? 1 : int'(pairs_reg));
      if (w > LINE_MAX) w = LINE_MAX;
      return w;
    endfunction

    function int unsigned pending();
      return pixels_due.size();
    endfunction

    // true if this item would complete a block over line entries never filled
    function bit reads_unseen(hd2_pkg::pix_t it);
      if (it.frame_start || !in_lower || (col_pos % 2) == 0) return 0;
      return !(line_seen[col_pos - 1] && line_seen[col_pos]);
    endfunction

    function int keep_sum(int s);
      int m;
      m = (s < 0) ? -s : s;
      return (m < int'(thresh_reg)) ? 0 : s;
    endfunction

    // divide by four, half away from zero, clamp to pixel range
    function logic [PIX_B-1:0] round_clamp(int v4);
      int q;
      if (v4 <= 0) return '0;
      q = (v4 + 2) / 4;
      return (q > 255) ? 8'd255 : q[PIX_B-1:0];
    endfunction

    function void take_pixel(hd2_pkg::pix_t it);
      int unsigned w;
      int unsigned col;
      int a, b, c, d, ll, lh, hl, hh;
      int v [4];
      hd2_pkg::res_t r;
      w = line_len();
      if (it.frame_start) begin
        col_pos = 0;
        in_lower = 0;
      end
      col = col_pos % LINE_MAX;
      if (!in_lower) begin
        line_mem[col] = it.pixel;
        line_seen[col] = 1;
      end else if ((col % 2) == 0) begin
        left_px = it.pixel;
      end else begin
        a = int'(line_mem[col - 1]);
        b = int'(line_mem[col]);
        c = int'(left_px);
        d = int'(it.pixel);
        ll = keep_sum(a + b + c + d);
        lh = keep_sum(a + b - c - d);
        hl = keep_sum(a - b + c - d);
        hh = keep_sum(a - b - c + d);
        v[0] = ll + lh + hl + hh;
        v[1] = ll + lh - hl - hh;
        v[2] = ll - lh + hl - hh;
        v[3] = ll - lh - hl + hh;
        for (int k = 0; k < 4; k++) begin
          r.out_pixel = round_clamp(v[k]);
          r.out_column = ((k % 2) == 1) ? col[COL_B-1:0] : (col[COL_B-1:0] - 1'b1);
          r.lower_row = (k >= 2);
          r.block_last = (k == 3);
          pixels_due.push_back(r);
        end
      end
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        in_lower = !in_lower;
      end else begin
        col_pos++;
      end
    endfunction

    function void note_diff(string field, logic [15:0] want, logic [15:0] got);
      n_bad++;
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_pixel(hd2_pkg::res_t got);
      hd2_pkg::res_t want;
      if (pixels_due.size() == 0) begin
        n_bad++;
        $display("%0t ns: unexpected pixel, expected none actual %0d col %0d",
                 $time, got.out_pixel, got.out_column);
        return;
      end
      want = pixels_due.pop_front();
      if (got.out_pixel !== want.out_pixel)
        note_diff("out_pixel", 16'(want.out_pixel), 16'(got.out_pixel));
      if (got.out_column !== want.out_column)
        note_diff("out_column", 16'(want.out_column), 16'(got.out_column));
      if (got.lower_row !== want.lower_row)
        note_diff("lower_row", 16'(want.lower_row), 16'(got.lower_row));
      if (got.block_last !== want.block_last)
        note_diff("block_last", 16'(want.block_last), 16'(got.block_last));
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [0:0]       cfg_idx;
  logic [CFG_B-1:0] cfg_wdata;
  bit               gappy;
  bit               hold_req;
  haar_denoise_sb   sb;

  hd2_pix_if pix ();
  hd2_res_if res ();

  haar_2x2_threshold_denoise #(
    .MAX_LINE_WIDTH(LINE_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pix_i      (pix),
    .res_o      (res)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [PIX_B-1:0] pick_pixel(int base, int spread);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'd0;
    if (r < 10) return 8'd255;
    if (r < 25) return PIX_B'($urandom_range(0, 255));
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_B-1:0];
  endfunction

  task automatic write_reg(hd2_pkg::cfg_reg_e idx, logic [CFG_B-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_item(hd2_pkg::pix_t it);
    int unsigned gap;
    gap = gappy ? gap_len() : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // never let a lower row read a line entry that no upper row has filled
    if (sb.reads_unseen(it)) it.frame_start = 1'b1;
    pix.valid <= 1'b1;
    pix.data <= it;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    sb.take_pixel(it);
  endtask

  task automatic send_px(logic [PIX_B-1:0] px, logic fs);
    hd2_pkg::pix_t it;
    it.pixel = px;
    it.frame_start = fs;
    send_item(it);
  endtask

  // called at the step of the last accepted item
  task automatic end_phase();
    pix.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned n_items, bit noisy);
    int unsigned frame_len;
    int unsigned in_frame;
    int base;
    int spread;
    hd2_pkg::pix_t it;
    frame_len = 0;
    in_frame = 0;
    base = 0;
    spread = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (in_frame == frame_len) begin
        in_frame = 0;
        frame_len = sb.line_len() * 2 * $urandom_range(1, 3);
        base = $urandom_range(0, 255);
        case ($urandom_range(0, 4))
          0: spread = 0;
          1: spread = 2;
          2: spread = 6;
          3: spread = 20;
          default: spread = 128;
        endcase
      end
      it.frame_start = (in_frame == 0) || (noisy && $urandom_range(0, 99) < 3);
      it.pixel = pick_pixel(base, spread);
      send_item(it);
      in_frame++;
    end
    end_phase();
  endtask

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, long ready stretches, and one long hold on request
  initial begin
    int unsigned go_left;
    int unsigned stall_left;
    int unsigned r;
    bit          hold_done;
    go_left = 0;
    stall_left = 0;
    hold_done = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res.valid && res.ready) sb.check_pixel(res.data);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        stall_left = 400;
        go_left = 0;
      end
      if (stall_left == 0 && go_left == 0) begin
        r = $urandom_range(0, 99);
        go_left = (r < 10) ? $urandom_range(60, 200) : $urandom_range(1, 8);
        r = $urandom_range(0, 99);
        if (r < 40) stall_left = 0;
        else if (r < 90) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(10, 30);
      end
      if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        go_left--;
        res.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned done_items;
    int unsigned n;
    logic [CFG_B-1:0] pairs;
    logic [CFG_B-1:0] thresh;
    sb = new();
    gappy = 1;
    hold_req = 0;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= hd2_pkg::REG_PAIRS;
    cfg_wdata <= '0;
    pix.valid <= 1'b0;
    pix.data <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no threshold: exact inverse, including the largest sums
    write_reg(hd2_pkg::REG_PAIRS, 10'd1);
    write_reg(hd2_pkg::REG_THRESH, 10'd0);
    send_px(8'd255, 1'b1);
    send_px(8'd0, 1'b0);
    send_px(8'd0, 1'b0);
    send_px(8'd255, 1'b0);
    send_px(8'd255, 1'b0);
    send_px(8'd255, 1'b0);
    send_px(8'd255, 1'b0);
    send_px(8'd255, 1'b0);
    end_phase();
    // threshold above every sum zeroes the average too
    write_reg(hd2_pkg::REG_THRESH, 10'd1021);
    repeat (4) send_px(8'd255, 1'b0);
    end_phase();
    // frame start inside a lower row restarts at the upper row
    write_reg(hd2_pkg::REG_THRESH, hd2_pkg::THRESH_RST);
    send_px(8'd20, 1'b1);
    send_px(8'd30, 1'b0);
    send_px(8'd40, 1'b0);
    send_px(8'd50, 1'b1);
    send_px(8'd60, 1'b0);
    send_px(8'd70, 1'b0);
    send_px(8'd80, 1'b0);
    end_phase();
    // line shrinks mid-row, so the column is already past the new width
    write_reg(hd2_pkg::REG_PAIRS, 10'd4);
    send_px(8'd90, 1'b1);
    send_px(8'd100, 1'b0);
    send_px(8'd110, 1'b0);
    end_phase();
    write_reg(hd2_pkg::REG_PAIRS, 10'd1);
    send_px(8'd120, 1'b0);
    send_px(8'd130, 1'b0);
    send_px(8'd140, 1'b0);
    end_phase();

    // long result-side hold while pixels keep coming
    gappy = 0;
    write_reg(hd2_pkg::REG_PAIRS, 10'd3);
    write_reg(hd2_pkg::REG_THRESH, 10'd41);
    hold_req = 1;
    run_phase(150, 1'b0);
    done_items = 150;

    while (done_items < 340) begin
      case ($urandom_range(0, 9))
        0: pairs = 10'd0;
        1: pairs = 10'd1;
        2: pairs = CFG_B'($urandom_range(9, 64));
        default: pairs = CFG_B'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0: thresh = 10'd0;
        1: thresh = 10'd1021;
        2: thresh = 10'd1023;
        5: thresh = CFG_B'($urandom_range(0, 1023));
        default: thresh = CFG_B'($urandom_range(1, 80));
      endcase
      write_reg(hd2_pkg::REG_PAIRS, pairs);
      write_reg(hd2_pkg::REG_THRESH, thresh);
      gappy = ($urandom_range(0, 3) != 0);
      n = $urandom_range(30, 80);
      run_phase(n, 1'b1);
      done_items += n;
    end

    // widest settings: register above the line store size, then at it
    gappy = 1;
    write_reg(hd2_pkg::REG_PAIRS, 10'd1023);
    write_reg(hd2_pkg::REG_THRESH, CFG_B'($urandom_range(10, 60)));
    run_phase(40, 1'b0);
    write_reg(hd2_pkg::REG_PAIRS, 10'd512);
    run_phase(30, 1'b1);
    write_reg(hd2_pkg::REG_PAIRS, 10'd2);
    write_reg(hd2_pkg::REG_THRESH, CFG_B'($urandom_range(0, 100)));
    run_phase(30, 1'b1);

    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
